@@ rtl/core/ipv4_rx_frame_classifier_macros.svh @@
// assertion macros for the frame classifier
`ifndef IPV4_RX_FRAME_CLASSIFIER_MACROS_SVH
`define IPV4_RX_FRAME_CLASSIFIER_MACROS_SVH

// implication checked on every clock edge outside reset
`define IRFC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define IRFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/irfc_pkg.sv @@
package irfc_pkg;

  localparam int unsigned MaxFrameBytes = 2048;
  localparam int unsigned PosW          = 12;
  localparam int unsigned ListenerSlots = 4;
  localparam int unsigned QueueDepth    = 2;

  typedef enum logic [2:0] {
    VERDICT_DROP     = 3'd0,
    VERDICT_ARP_LRN  = 3'd1,
    VERDICT_ARP_REQ  = 3'd2,
    VERDICT_ECHO_REQ = 3'd3,
    VERDICT_ECHO_REP = 3'd4,
    VERDICT_UDP      = 3'd5
  } verdict_e;

  localparam logic [2:0] RegLocalIp  = 3'd0;
  localparam logic [2:0] RegLstCount = 3'd1;
  localparam logic [2:0] RegLstPort0 = 3'd2;
  localparam logic [2:0] RegLstPort1 = 3'd3;
  localparam logic [2:0] RegLstPort2 = 3'd4;
  localparam logic [2:0] RegLstPort3 = 3'd5;

  localparam logic [15:0] EtherArp  = 16'h0806;
  localparam logic [15:0] EtherIpv4 = 16'h0800;
  localparam logic [15:0] ArpHwEther   = 16'd1;
  localparam logic [15:0] ArpOpRequest = 16'd1;
  localparam logic [7:0]  ProtoIcmp = 8'd1;
  localparam logic [7:0]  ProtoUdp  = 8'd17;
  localparam logic [7:0]  IcmpEchoRequest = 8'd8;
  localparam logic [7:0]  IcmpEchoReply   = 8'd0;

  // captured frame summary handed from the parser to the classifier
  typedef struct packed {
    logic        oversize;
    logic [PosW-1:0] len;
    logic [15:0] ether_kind;
    logic [15:0] arp_htype;
    logic [15:0] arp_ptype;
    logic [15:0] arp_oper;
    logic [47:0] arp_sha;
    logic [31:0] arp_spa;
    logic [31:0] arp_tpa;
    logic [7:0]  vi;
    logic [15:0] total;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    logic [16:0] hsum;
    logic [16:0] isum;
    logic [7:0]  icmp_type;
    logic [7:0]  icmp_code;
    logic [15:0] ident;
    logic [15:0] seqn;
    logic [15:0] udp_sport;
    logic [15:0] udp_dport;
    logic [15:0] udp_len;
  } frame_sum_t;

  function automatic logic [16:0] oc_add(logic [16:0] s, logic odd, logic [7:0] b);
    logic [17:0] t;
    t = {1'b0, s} + (odd ? {10'd0, b} : {2'd0, b, 8'd0});
    return {1'b0, t[15:0]} + {15'd0, t[17:16]};
  endfunction

endpackage

@@ rtl/core/irfc_parser.sv @@
module irfc_parser import irfc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       sum_valid_o,
  input  logic       sum_ready_i,
  output frame_sum_t sum_o
);

  logic [PosW-1:0] pos_q;
  frame_sum_t f_q, f_d;
  logic take;
  logic [PosW-1:0] r;
  logic [7:0] vi_cur;
  logic [5:0] ihl;
  logic [PosW-1:0] q;
  logic in_body;

  assign in_ready_o  = sum_ready_i;
  assign take        = in_valid_i && in_ready_o;
  assign sum_valid_o = take && last_byte_i;
  assign r   = pos_q - PosW'(14);
  // the version byte already counts on the byte that carries it
  assign vi_cur = (pos_q == PosW'(14)) ? data_byte_i : f_q.vi;
  assign ihl = {vi_cur[3:0], 2'b00};
  assign q   = r - PosW'(ihl);
  assign in_body = (ihl != 6'd0) && (r >= PosW'(ihl)) && ({4'd0, r} < f_q.total);

  always_comb begin
    f_d = f_q;
    if (pos_q >= PosW'(MaxFrameBytes)) begin
      f_d.oversize = 1'b1;
    end else begin
      f_d.len = pos_q + PosW'(1);
      if (pos_q == PosW'(12) || pos_q == PosW'(13)) f_d.ether_kind = {f_q.ether_kind[7:0], data_byte_i};
      if (pos_q >= PosW'(14)) begin
        if (r <= PosW'(1)) f_d.arp_htype = {f_q.arp_htype[7:0], data_byte_i};
        else if (r <= PosW'(3)) f_d.arp_ptype = {f_q.arp_ptype[7:0], data_byte_i};
        if (r == PosW'(6) || r == PosW'(7)) f_d.arp_oper = {f_q.arp_oper[7:0], data_byte_i};
        if (r >= PosW'(8) && r <= PosW'(13)) f_d.arp_sha = {f_q.arp_sha[39:0], data_byte_i};
        if (r >= PosW'(14) && r <= PosW'(17)) f_d.arp_spa = {f_q.arp_spa[23:0], data_byte_i};
        if (r >= PosW'(24) && r <= PosW'(27)) f_d.arp_tpa = {f_q.arp_tpa[23:0], data_byte_i};
        if (r == PosW'(0)) f_d.vi = data_byte_i;
        if (r == PosW'(2) || r == PosW'(3)) f_d.total = {f_q.total[7:0], data_byte_i};
        if (r == PosW'(9)) f_d.proto = data_byte_i;
        if (r >= PosW'(12) && r <= PosW'(15)) f_d.src = {f_q.src[23:0], data_byte_i};
        if (r >= PosW'(16) && r <= PosW'(19)) f_d.dst = {f_q.dst[23:0], data_byte_i};
        if (r < PosW'(ihl)) f_d.hsum = oc_add(f_q.hsum, r[0], data_byte_i);
        if (in_body) begin
          f_d.isum = oc_add(f_q.isum, q[0], data_byte_i);
          if (q == PosW'(0)) f_d.icmp_type = data_byte_i;
          if (q == PosW'(1)) f_d.icmp_code = data_byte_i;
          if (q == PosW'(4) || q == PosW'(5)) f_d.ident = {f_q.ident[7:0], data_byte_i};
          if (q == PosW'(6) || q == PosW'(7)) f_d.seqn = {f_q.seqn[7:0], data_byte_i};
          if (q <= PosW'(1)) f_d.udp_sport = {f_q.udp_sport[7:0], data_byte_i};
          else if (q <= PosW'(3)) f_d.udp_dport = {f_q.udp_dport[7:0], data_byte_i};
          else if (q <= PosW'(5)) f_d.udp_len = {f_q.udp_len[7:0], data_byte_i};
        end
      end
    end
  end

  // summary already includes the byte being taken
  assign sum_o = f_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      f_q   <= '0;
    end else if (take) begin
      if (last_byte_i) begin
        pos_q <= '0;
        f_q   <= '0;
      end else begin
        pos_q <= f_d.len;
        f_q   <= f_d;
      end
    end
  end

endmodule

@@ rtl/core/irfc_queue.sv @@
module irfc_queue import irfc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_valid_i,
  output logic       wr_ready_o,
  input  frame_sum_t wr_data_i,
  output logic       rd_valid_o,
  input  logic       rd_ready_i,
  output frame_sum_t rd_data_o
);

  frame_sum_t mem_q [QueueDepth];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;

  assign wr_ready_o = cnt_q != 2'(QueueDepth);
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

@@ rtl/core/irfc_classify.sv @@
module irfc_classify import irfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] local_ip_i,
  input  logic [2:0]  listener_count_i,
  input  logic [15:0] port0_i,
  input  logic [15:0] port1_i,
  input  logic [15:0] port2_i,
  input  logic [15:0] port3_i,
  input  logic        sum_valid_i,
  output logic        sum_ready_o,
  input  frame_sum_t  sum_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  verdict_o,
  output logic [1:0]  listener_index_o,
  output logic [31:0] sender_ip_o,
  output logic [47:0] sender_mac_o,
  output logic [15:0] source_port_o,
  output logic [15:0] echo_ident_o,
  output logic [15:0] echo_sequence_o,
  output logic [10:0] data_offset_o,
  output logic [10:0] data_length_o,
  output logic [31:0] reply_count_o
);

  logic [PosW-1:0] pl;
  logic [5:0] ihl;
  logic [15:0] plen;
  logic ip_ok, udp_hit;
  logic [1:0] hit_idx;
  logic [2:0] n;
  logic [15:0] ports [ListenerSlots];
  verdict_e v;
  logic [31:0] sip, rc_d, rc_q;
  logic [47:0] smac;
  logic [15:0] sport, eid, eseq;
  logic [10:0] doff, dlen;
  logic take;

  assign ports[0] = port0_i;
  assign ports[1] = port1_i;
  assign ports[2] = port2_i;
  assign ports[3] = port3_i;
  assign pl   = sum_i.len - PosW'(14);
  assign ihl  = {sum_i.vi[3:0], 2'b00};
  assign plen = sum_i.total - {10'd0, ihl};
  assign n    = (listener_count_i > 3'd4) ? 3'd4 : listener_count_i;
  assign ip_ok = !sum_i.oversize && sum_i.len >= PosW'(14) && sum_i.ether_kind == EtherIpv4
    && pl >= PosW'(20) && (sum_i.vi & 8'hF0) == 8'h40
    && {4'd0, pl} >= sum_i.total && sum_i.total >= {10'd0, ihl}
    && sum_i.dst == local_ip_i && sum_i.hsum == 17'hFFFF && plen >= 16'd8;

  always_comb begin
    udp_hit = 1'b0;
    hit_idx = '0;
    for (int i = ListenerSlots - 1; i >= 0; i--) begin
      if (3'(i) < n && ports[i] == sum_i.udp_dport) begin
        udp_hit = 1'b1;
        hit_idx = 2'(i);
      end
    end
  end

  always_comb begin
    v = VERDICT_DROP;
    sip = '0; smac = '0; sport = '0; eid = '0; eseq = '0; doff = '0; dlen = '0;
    rc_d = rc_q;
    if (!sum_i.oversize && sum_i.len >= PosW'(14) && sum_i.ether_kind == EtherArp) begin
      if (pl >= PosW'(28) && sum_i.arp_htype == ArpHwEther && sum_i.arp_ptype == EtherIpv4) begin
        v = (sum_i.arp_oper == ArpOpRequest && sum_i.arp_tpa == local_ip_i) ?
          VERDICT_ARP_REQ : VERDICT_ARP_LRN;
        sip = sum_i.arp_spa;
        smac = sum_i.arp_sha;
      end
    end else if (ip_ok && sum_i.proto == ProtoIcmp) begin
      if (sum_i.isum == 17'hFFFF && sum_i.icmp_code == 8'd0 &&
          (sum_i.icmp_type == IcmpEchoRequest || sum_i.icmp_type == IcmpEchoReply)) begin
        if (sum_i.icmp_type == IcmpEchoRequest) v = VERDICT_ECHO_REQ;
        else begin
          v = VERDICT_ECHO_REP;
          rc_d = rc_q + 32'd1;
        end
        sip = sum_i.src;
        eid = sum_i.ident;
        eseq = sum_i.seqn;
        doff = 11'd22 + {5'd0, ihl};
        dlen = plen[10:0] - 11'd8;
      end
    end else if (ip_ok && sum_i.proto == ProtoUdp) begin
      if (sum_i.udp_len >= 16'd8 && sum_i.udp_len <= plen && udp_hit) begin
        v = VERDICT_UDP;
        sip = sum_i.src;
        sport = sum_i.udp_sport;
        doff = 11'd22 + {5'd0, ihl};
        dlen = sum_i.udp_len[10:0] - 11'd8;
      end
    end
  end

  // output register doubles as the result holding stage
  assign sum_ready_o = !out_valid_o || out_ready_i;
  assign take = sum_valid_i && sum_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
      rc_q <= '0;
    end else begin
      if (take) begin
        out_valid_o <= 1'b1;
        rc_q <= rc_d;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      verdict_o <= v;
      listener_index_o <= (v == VERDICT_UDP) ? hit_idx : 2'd0;
      sender_ip_o <= sip;
      sender_mac_o <= smac;
      source_port_o <= sport;
      echo_ident_o <= eid;
      echo_sequence_o <= eseq;
      data_offset_o <= doff;
      data_length_o <= dlen;
      reply_count_o <= rc_d;
    end
  end

endmodule

@@ rtl/core/ipv4_rx_frame_classifier.sv @@
// channel | dir | handshake                    | payload
// in      | in  | in_valid_i / in_ready_o      | data_byte_i, last_byte_i
// out     | out | out_valid_o / out_ready_i    | verdict_o .. reply_count_o
// cfg     | in  | cfg_we_i                     | cfg_index_i, cfg_data_i
// one byte per cycle while the queue has room; the parser captures fields and sums
// as bytes pass; the last byte writes the queue, which feeds the output register
// reset clears frame state, the reply count and the configuration registers
// the parser stalls only when the two-entry summary queue is full
module ipv4_rx_frame_classifier import irfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  verdict_o,
  output logic [1:0]  listener_index_o,
  output logic [31:0] sender_ip_o,
  output logic [47:0] sender_mac_o,
  output logic [15:0] source_port_o,
  output logic [15:0] echo_ident_o,
  output logic [15:0] echo_sequence_o,
  output logic [10:0] data_offset_o,
  output logic [10:0] data_length_o,
  output logic [31:0] reply_count_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] local_ip_q;
  logic [2:0]  lst_count_q;
  logic [15:0] port_q [ListenerSlots];
  frame_sum_t  p_sum, q_sum;
  logic p_valid, p_ready, q_valid, q_ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_ip_q <= '0;
      lst_count_q <= '0;
      for (int i = 0; i < ListenerSlots; i++) port_q[i] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegLocalIp:  local_ip_q <= cfg_data_i;
        RegLstCount: lst_count_q <= cfg_data_i[2:0];
        RegLstPort0: port_q[0] <= cfg_data_i[15:0];
        RegLstPort1: port_q[1] <= cfg_data_i[15:0];
        RegLstPort2: port_q[2] <= cfg_data_i[15:0];
        RegLstPort3: port_q[3] <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // front: byte capture
  irfc_parser u_parser (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .data_byte_i, .last_byte_i,
    .sum_valid_o(p_valid), .sum_ready_i(p_ready), .sum_o(p_sum)
  );

  // frame summary queue
  irfc_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(p_valid), .wr_ready_o(p_ready), .wr_data_i(p_sum),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_data_o(q_sum)
  );

  // back: verdict and output register
  irfc_classify u_classify (
    .clk_i, .rst_ni, .local_ip_i(local_ip_q), .listener_count_i(lst_count_q),
    .port0_i(port_q[0]), .port1_i(port_q[1]), .port2_i(port_q[2]), .port3_i(port_q[3]),
    .sum_valid_i(q_valid), .sum_ready_o(q_ready), .sum_i(q_sum),
    .out_valid_o, .out_ready_i, .verdict_o, .listener_index_o, .sender_ip_o,
    .sender_mac_o, .source_port_o, .echo_ident_o, .echo_sequence_o,
    .data_offset_o, .data_length_o, .reply_count_o
  );

endmodule

@@ rtl/core/irfc_checker.sv @@
`include "ipv4_rx_frame_classifier_macros.svh"
module irfc_checker import irfc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  verdict_o,
  input logic [1:0]  listener_index_o,
  input logic [47:0] sender_mac_o,
  input logic [31:0] reply_count_o
);
  `IRFC_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(verdict_o))
  `IRFC_ASSERT_IMP(a_range, clk_i, rst_ni, out_valid_o, verdict_o <= VERDICT_UDP)
  `IRFC_ASSERT_IMP(a_idx, clk_i, rst_ni, out_valid_o && verdict_o != VERDICT_UDP, listener_index_o == 2'd0)
  `IRFC_ASSERT_IMP(a_mac, clk_i, rst_ni, out_valid_o && verdict_o != VERDICT_ARP_LRN && verdict_o != VERDICT_ARP_REQ, sender_mac_o == 48'd0)
endmodule

bind ipv4_rx_frame_classifier irfc_checker u_irfc_checker (.*);

@@ bench/ipv4_rx_frame_classifier_tb.sv @@
`default_nettype none

module ipv4_rx_frame_classifier_tb;
  import irfc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 2000000;
  localparam logic [15:0] ArpOpReply   = 16'd2;
  localparam logic [3:0]  IpVersion4   = 4'd4;

  // one verdict as seen on the output port
  typedef struct packed {
    logic [2:0]  verdict;
    logic [1:0]  lst_idx;
    logic [31:0] sip;
    logic [47:0] smac;
    logic [15:0] sport;
    logic [15:0] ident;
    logic [15:0] seqn;
    logic [10:0] doff;
    logic [10:0] dlen;
    logic [31:0] replies;
  } verdict_rec_t;

  // frame shapes the generator knows how to build
  typedef enum int {
    FK_NOISE, FK_RUNT, FK_BARE_HEAD, FK_ARP_LEARN, FK_ARP_FOR_US, FK_ARP_BAD_TYPE,
    FK_ARP_SHORT, FK_ECHO_REQ, FK_ECHO_REP, FK_ICMP_OTHER, FK_ICMP_BAD_SUM,
    FK_UDP_HIT, FK_UDP_MISS, FK_UDP_BAD_LEN, FK_IP_ZERO_IHL, FK_IP_BAD_VER,
    FK_IP_OTHER_DST, FK_IP_BAD_SUM, FK_IP_TRUNC, FK_IP_SHORT_PAY, FK_IP_OTHER_PROTO,
    FK_COUNT
  } frame_kind_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'd0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  verdict_o;
  logic [1:0]  listener_index_o;
  logic [31:0] sender_ip_o;
  logic [47:0] sender_mac_o;
  logic [15:0] source_port_o;
  logic [15:0] echo_ident_o;
  logic [15:0] echo_sequence_o;
  logic [10:0] data_offset_o;
  logic [10:0] data_length_o;
  logic [31:0] reply_count_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = 3'd0;
  logic [31:0] cfg_data_i = 32'd0;

  ipv4_rx_frame_classifier dut (.*);

  // pending verdicts, oldest first
  verdict_rec_t verdict_q[$];
  int unsigned  mismatches = 0;
  int unsigned  cycles = 0;
  bit           calm = 1'b0;     // no idling on either side
  int unsigned  hold_req = 0;    // long receiver hold-off asked by a test

  // shadow of the configuration registers
  logic [31:0] cfg_ip = '0;
  logic [2:0]  cfg_count = '0;
  logic [15:0] cfg_port[4] = '{default: '0};

  // shadow of the parser state
  int unsigned pos;
  bit          ovf;
  logic [15:0] ekind, htype, ptype, oper, total, ident, seqn, sport, dport, ulen;
  logic [47:0] sha;
  logic [31:0] spa, tpa, src, dst, reply_total;
  logic [7:0]  vi, proto, icmp_kind, icmp_code;
  int unsigned hsum, isum;

  // frame under construction and the ip payload that goes in it
  logic [7:0] frm[$];
  logic [7:0] pay[$];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic int unsigned ones_add(int unsigned s, int unsigned rel, logic [7:0] b);
    s += rel[0] ? 32'(b) : (32'(b) << 8);
    return (s & 32'hFFFF) + (s >> 16);
  endfunction

  function automatic void clear_frame_state();
    pos = 0; ovf = 0; ekind = '0; htype = '0; ptype = '0; oper = '0; total = '0;
    ident = '0; seqn = '0; sport = '0; dport = '0; ulen = '0; sha = '0; spa = '0;
    tpa = '0; src = '0; dst = '0; vi = '0; proto = '0; icmp_kind = '0; icmp_code = '0;
    hsum = 0; isum = 0;
  endfunction

  function automatic void capture_byte(int unsigned p, logic [7:0] b);
    int unsigned r, ihl, q;
    if (p == 12 || p == 13) ekind = {ekind[7:0], b};
    if (p < 14) return;
    r = p - 14;
    // arp fields
    if (r <= 1) htype = {htype[7:0], b};
    else if (r <= 3) ptype = {ptype[7:0], b};
    if (r == 6 || r == 7) oper = {oper[7:0], b};
    if (r >= 8 && r <= 13) sha = {sha[39:0], b};
    if (r >= 14 && r <= 17) spa = {spa[23:0], b};
    if (r >= 24 && r <= 27) tpa = {tpa[23:0], b};
    // ipv4 fields, sharing the same byte positions
    if (r == 0) vi = b;
    if (r == 2 || r == 3) total = {total[7:0], b};
    if (r == 9) proto = b;
    if (r >= 12 && r <= 15) src = {src[23:0], b};
    if (r >= 16 && r <= 19) dst = {dst[23:0], b};
    ihl = vi[3:0];
    ihl = ihl * 4;
    if (r < ihl) hsum = ones_add(hsum, r, b);
    if (ihl > 0 && r >= ihl && r < total) begin
      q = r - ihl;
      isum = ones_add(isum, q, b);
      if (q == 0) icmp_kind = b;
      if (q == 1) icmp_code = b;
      if (q == 4 || q == 5) ident = {ident[7:0], b};
      if (q == 6 || q == 7) seqn = {seqn[7:0], b};
      if (q <= 1) sport = {sport[7:0], b};
      else if (q <= 3) dport = {dport[7:0], b};
      else if (q <= 5) ulen = {ulen[7:0], b};
    end
  endfunction

  function automatic verdict_rec_t classify_frame();
    verdict_rec_t r;
    int unsigned pl, ihl, plen, n;
    r = '0;
    if (ovf || pos < 14) return r;
    pl = pos - 14;
    if (ekind == EtherArp) begin
      if (pl < 28 || htype != ArpHwEther || ptype != EtherIpv4) return r;
      r.verdict = VERDICT_ARP_LRN;
      r.sip = spa;
      r.smac = sha;
      if (oper == ArpOpRequest && tpa == cfg_ip) r.verdict = VERDICT_ARP_REQ;
    end else if (ekind == EtherIpv4) begin
      ihl = vi[3:0];
      ihl = ihl * 4;
      if (pl < 20 || vi[7:4] != IpVersion4) return r;
      if (total > pl || ihl > total) return r;
      if (dst != cfg_ip || hsum != 32'hFFFF) return r;
      plen = total - ihl;
      if (plen < 8) return r;
      if (proto == ProtoIcmp) begin
        if (isum != 32'hFFFF || icmp_code != 8'd0) return r;
        if (icmp_kind == IcmpEchoRequest) r.verdict = VERDICT_ECHO_REQ;
        else if (icmp_kind == IcmpEchoReply) begin
          reply_total++;
          r.verdict = VERDICT_ECHO_REP;
        end else return r;
        r.sip = src;
        r.ident = ident;
        r.seqn = seqn;
        r.doff = 11'(14 + ihl + 8);
        r.dlen = 11'(plen - 8);
      end else if (proto == ProtoUdp) begin
        if (ulen < 8 || ulen > plen) return r;
        n = (cfg_count < ListenerSlots) ? cfg_count : ListenerSlots;
        for (int i = 0; i < n; i++) begin
          if (cfg_port[i] == dport) begin
            r.verdict = VERDICT_UDP;
            r.lst_idx = 2'(i);
            r.sip = src;
            r.sport = sport;
            r.doff = 11'(14 + ihl + 8);
            r.dlen = 11'(ulen - 8);
            return r;
          end
        end
      end
    end
    return r;
  endfunction

  // called for every accepted byte
  function automatic void predict_byte(logic [7:0] b, logic last);
    verdict_rec_t r;
    if (pos >= MaxFrameBytes) ovf = 1;
    else begin
      capture_byte(pos, b);
      pos++;
    end
    if (last) begin
      r = classify_frame();
      r.replies = reply_total;
      verdict_q.push_back(r);
      clear_frame_state();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // checker: one verdict per output transfer
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    verdict_rec_t got, want;
    if (out_valid_o && out_ready_i) begin
      got = '{verdict_o, listener_index_o, sender_ip_o, sender_mac_o, source_port_o,
              echo_ident_o, echo_sequence_o, data_offset_o, data_length_o, reply_count_o};
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected verdict %0d", got.verdict);
      end else begin
        want = verdict_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: verdict %0d/%0d idx %0d/%0d ip %h/%h mac %h/%h",
                     want.verdict, got.verdict, want.lst_idx, got.lst_idx,
                     want.sip, got.sip, want.smac, got.smac);
            $display("  sport %h/%h id %h/%h seq %h/%h off %0d/%0d len %0d/%0d rc %0d/%0d",
                     want.sport, got.sport, want.ident, got.ident, want.seqn, got.seqn,
                     want.doff, got.doff, want.dlen, got.dlen, want.replies, got.replies);
          end
        end
      end
    end
  end

  // receiver readiness: random stall bursts, plus the long hold-off on request
  initial begin
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        stall = hold_req;
        hold_req = 0;
      end
      if (stall == 0 && !calm && $urandom_range(0, 9) == 0) stall = $urandom_range(1, 13);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender and configuration
  // ---------------------------------------------------------------------------

  // every task returns right after a rising edge
  task automatic send_byte(logic [7:0] b, logic last);
    int unsigned gap;
    if (!calm && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    predict_byte(b, last);
  endtask

  // valid stays up between frames; the next byte or an idle wait takes it over
  task automatic send_frame();
    foreach (frm[i]) send_byte(frm[i], i == frm.size() - 1);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    // verdict path runs through the queue and the output register; leave some margin
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegLocalIp:  cfg_ip = v;
      RegLstCount: cfg_count = v[2:0];
      RegLstPort0: cfg_port[0] = v[15:0];
      RegLstPort1: cfg_port[1] = v[15:0];
      RegLstPort2: cfg_port[2] = v[15:0];
      RegLstPort3: cfg_port[3] = v[15:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic apply_setting(logic [31:0] ip, logic [2:0] n, logic [15:0] p0,
                               logic [15:0] p1, logic [15:0] p2, logic [15:0] p3);
    wait_drained();
    write_reg(RegLocalIp, ip);
    write_reg(RegLstCount, {29'd0, n});
    write_reg(RegLstPort0, {16'd0, p0});
    write_reg(RegLstPort1, {16'd0, p1});
    write_reg(RegLstPort2, {16'd0, p2});
    write_reg(RegLstPort3, {16'd0, p3});
  endtask

  // ---------------------------------------------------------------------------
  // frame builders
  // ---------------------------------------------------------------------------

  function automatic void put_rand(int unsigned n);
    repeat (n) frm.push_back(8'($urandom));
  endfunction

  function automatic void put16(logic [15:0] v);
    frm.push_back(v[15:8]);
    frm.push_back(v[7:0]);
  endfunction

  function automatic void put32(logic [31:0] v);
    put16(v[31:16]);
    put16(v[15:0]);
  endfunction

  // internet checksum of q[start +: len], as it goes into the header
  function automatic logic [15:0] inet_sum(logic [7:0] q[$], int unsigned start,
                                           int unsigned len);
    int unsigned s;
    s = 0;
    for (int unsigned i = 0; i < len; i++)
      s += (i % 2 == 0) ? (32'(q[start + i]) << 8) : 32'(q[start + i]);
    while (s >> 16) s = (s & 32'hFFFF) + (s >> 16);
    return ~s[15:0];
  endfunction

  function automatic void eth_head(logic [15:0] kind);
    put_rand(12);
    put16(kind);
  endfunction

  function automatic void build_arp(logic [15:0] ht, logic [15:0] pt, logic [15:0] op,
                                    logic [31:0] target);
    eth_head(EtherArp);
    put16(ht);
    put16(pt);
    frm.push_back(8'd6);
    frm.push_back(8'd4);
    put16(op);
    put_rand(10);           // sender hardware and protocol address
    put_rand(6);
    put32(target);
    put_rand($urandom_range(0, 18));
  endfunction

  // ipv4 frame around pay; a header length under five words keeps a 20-byte header
  function automatic void build_ip(logic [3:0] ver, logic [3:0] ihl_w, logic [7:0] prot,
                                   logic [31:0] to_ip, bit sum_ok);
    int unsigned base, hl;
    logic [15:0] c;
    hl = (ihl_w >= 5) ? ihl_w * 4 : 20;
    eth_head(EtherIpv4);
    base = frm.size();
    frm.push_back({ver, ihl_w});
    put_rand(1);
    put16(16'(hl + pay.size()));
    put_rand(5);
    frm.push_back(prot);
    put16(16'd0);
    put_rand(4);
    put32(to_ip);
    put_rand(hl - 20);
    c = inet_sum(frm, base, hl);
    if (!sum_ok) c ^= 16'(1 << $urandom_range(0, 15));
    frm[base + 10] = c[15:8];
    frm[base + 11] = c[7:0];
    foreach (pay[i]) frm.push_back(pay[i]);
    put_rand($urandom_range(0, 4));
  endfunction

  function automatic void build_icmp(logic [7:0] kind, logic [7:0] code, int unsigned n,
                                     bit sum_ok);
    logic [15:0] c;
    pay.delete();
    pay.push_back(kind);
    pay.push_back(code);
    pay.push_back(8'd0);
    pay.push_back(8'd0);
    repeat (4 + n) pay.push_back(8'($urandom));
    c = inet_sum(pay, 0, pay.size());
    if (!sum_ok) c ^= 16'(1 << $urandom_range(0, 15));
    pay[2] = c[15:8];
    pay[3] = c[7:0];
  endfunction

  function automatic void build_udp(logic [15:0] to_port, int unsigned n, int ulen_adj);
    logic [15:0] ul;
    pay.delete();
    ul = 16'(8 + n + ulen_adj);
    repeat (2) pay.push_back(8'($urandom));
    pay.push_back(to_port[15:8]);
    pay.push_back(to_port[7:0]);
    pay.push_back(ul[15:8]);
    pay.push_back(ul[7:0]);
    repeat (2 + n) pay.push_back(8'($urandom));
  endfunction

  function automatic logic [3:0] pick_ihl();
    return ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
  endfunction

  function automatic void make_frame(frame_kind_e k);
    int unsigned n, eff;
    logic [7:0] other;
    frm.delete();
    case (k)
      FK_NOISE: begin
        put_rand($urandom_range(1, 70));
      end
      FK_RUNT: begin
        put_rand($urandom_range(1, 13));
      end
      FK_BARE_HEAD: begin
        eth_head($urandom_range(0, 1) ? EtherArp : EtherIpv4);
      end
      FK_ARP_LEARN: begin
        build_arp(ArpHwEther, EtherIpv4, $urandom_range(0, 1) ? ArpOpReply : ArpOpRequest,
                  $urandom);
      end
      FK_ARP_FOR_US: begin
        build_arp(ArpHwEther, EtherIpv4, ArpOpRequest, cfg_ip);
      end
      FK_ARP_BAD_TYPE: begin
        if ($urandom_range(0, 1)) build_arp(16'($urandom), EtherIpv4, ArpOpRequest, cfg_ip);
        else build_arp(ArpHwEther, 16'($urandom), ArpOpRequest, cfg_ip);
      end
      FK_ARP_SHORT: begin
        build_arp(ArpHwEther, EtherIpv4, ArpOpRequest, cfg_ip);
        frm = frm[0 : 14 + $urandom_range(0, 27) - 1];
      end
      FK_ECHO_REQ, FK_ECHO_REP, FK_ICMP_OTHER, FK_ICMP_BAD_SUM: begin
        other = 8'($urandom);
        if (other == IcmpEchoRequest || other == IcmpEchoReply) other = 8'd3;
        case (k)
          FK_ECHO_REQ: build_icmp(IcmpEchoRequest, 8'd0, $urandom_range(0, 24), 1);
          FK_ECHO_REP: build_icmp(IcmpEchoReply, 8'd0, $urandom_range(0, 24), 1);
          FK_ICMP_OTHER: begin
            // either an unknown type or an echo with a nonzero code
            if ($urandom_range(0, 1)) build_icmp(other, 8'd0, $urandom_range(0, 8), 1);
            else build_icmp(IcmpEchoRequest, 8'($urandom_range(1, 255)), 4, 1);
          end
          default: build_icmp(IcmpEchoRequest, 8'd0, $urandom_range(0, 8), 0);
        endcase
        build_ip(IpVersion4, pick_ihl(), ProtoIcmp, cfg_ip, 1);
      end
      FK_UDP_HIT, FK_UDP_MISS, FK_UDP_BAD_LEN: begin
        eff = (cfg_count < ListenerSlots) ? cfg_count : ListenerSlots;
        if (k == FK_UDP_HIT && eff > 0)
          build_udp(cfg_port[$urandom_range(0, eff - 1)], $urandom_range(0, 24), 0);
        else if (k == FK_UDP_BAD_LEN)
          build_udp(cfg_port[0], 4, $urandom_range(0, 1) ? -($urandom_range(1, 12))
                                                          : $urandom_range(1, 20));
        else
          build_udp(16'($urandom), $urandom_range(0, 24), 0);
        build_ip(IpVersion4, pick_ihl(), ProtoUdp, cfg_ip, 1);
      end
      FK_IP_ZERO_IHL: begin
        build_icmp(IcmpEchoRequest, 8'd0, 4, 1);
        build_ip(IpVersion4, 4'($urandom_range(0, 4)), ProtoIcmp, cfg_ip, 1);
      end
      FK_IP_BAD_VER: begin
        build_icmp(IcmpEchoRequest, 8'd0, 4, 1);
        n = $urandom_range(0, 15);
        if (n == IpVersion4) n = 6;
        build_ip(4'(n), 4'd5, ProtoIcmp, cfg_ip, 1);
      end
      FK_IP_OTHER_DST: begin
        build_icmp(IcmpEchoRequest, 8'd0, 4, 1);
        build_ip(IpVersion4, 4'd5, ProtoIcmp, cfg_ip ^ (32'd1 << $urandom_range(0, 31)), 1);
      end
      FK_IP_BAD_SUM: begin
        build_udp(cfg_port[0], 4, 0);
        build_ip(IpVersion4, pick_ihl(), ProtoUdp, cfg_ip, 0);
      end
      FK_IP_TRUNC: begin
        // total length claims more bytes than the frame carries
        build_icmp(IcmpEchoRequest, 8'd0, 20, 1);
        build_ip(IpVersion4, 4'd5, ProtoIcmp, cfg_ip, 1);
        frm = frm[0 : 34 + $urandom_range(0, 27) - 1];
      end
      FK_IP_SHORT_PAY: begin
        pay.delete();
        repeat ($urandom_range(0, 7)) pay.push_back(8'($urandom));
        build_ip(IpVersion4, 4'd5, $urandom_range(0, 1) ? ProtoIcmp : ProtoUdp, cfg_ip, 1);
      end
      default: begin
        other = 8'($urandom);
        if (other == ProtoIcmp || other == ProtoUdp) other = 8'd6;
        build_udp(cfg_port[0], 4, 0);
        build_ip(IpVersion4, 4'd5, other, cfg_ip, 1);
      end
    endcase
    // a stray bit flip now and then in otherwise good frames
    if (k inside {FK_ARP_LEARN, FK_ECHO_REQ, FK_ECHO_REP, FK_UDP_HIT} &&
        $urandom_range(0, 9) == 0)
      frm[$urandom_range(0, frm.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
  endfunction

  // well-formed traffic most of the time, the rest broken or noise
  function automatic frame_kind_e pick_kind();
    case ($urandom_range(0, 9))
      0, 1: return FK_UDP_HIT;
      2: return FK_ECHO_REQ;
      3: return FK_ECHO_REP;
      4: return FK_ARP_LEARN;
      5: return FK_ARP_FOR_US;
      default: return frame_kind_e'($urandom_range(0, FK_COUNT - 1));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // every frame shape once, plus all-zero and all-one bytes
  task automatic test_every_kind();
    apply_setting(32'hC0A8_0001, 3'd4, 16'd7, 16'd0, 16'hFFFF, 16'd53);
    for (int k = 0; k < FK_COUNT; k++) begin
      make_frame(frame_kind_e'(k));
      send_frame();
    end
    frm.delete();
    repeat (40) frm.push_back(8'h00);
    send_frame();
    frm.delete();
    repeat (40) frm.push_back(8'hFF);
    send_frame();
  endtask

  // frames at the size limit and at least one byte past it
  task automatic test_size_limit();
    make_frame(FK_ECHO_REQ);
    while (frm.size() < MaxFrameBytes) frm.push_back(8'($urandom));
    send_frame();
    make_frame(FK_UDP_HIT);
    while (frm.size() < MaxFrameBytes + 1 + $urandom_range(0, 40)) frm.push_back(8'($urandom));
    send_frame();
    make_frame(FK_ARP_LEARN);
    send_frame();
  endtask

  // listener count past the slots and at zero
  task automatic test_listener_edges();
    apply_setting(32'hFFFF_FFFF, 3'd7, 16'hFFFF, 16'hFFFF, 16'd0, 16'd9);
    repeat (6) begin
      make_frame(FK_UDP_HIT);
      send_frame();
    end
    apply_setting(32'd0, 3'd0, 16'd0, 16'd1, 16'd2, 16'd3);
    repeat (4) begin
      make_frame($urandom_range(0, 1) ? FK_UDP_MISS : FK_ARP_FOR_US);
      send_frame();
    end
  endtask

  // hold the receiver off so the summary queue fills and the input stalls
  task automatic test_backpressure();
    hold_req = 400;
    repeat (10) begin
      make_frame(FK_RUNT);
      send_frame();
    end
    // sender waits for every verdict before going on
    wait_drained();
  endtask

  task automatic test_random_traffic(int unsigned frames);
    for (int unsigned i = 0; i < frames; i++) begin
      make_frame(pick_kind());
      send_frame();
    end
  endtask

  initial begin
    clear_frame_state();
    reply_total = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // a few frames on reset values of the registers
    test_random_traffic(4);
    test_every_kind();
    test_size_limit();
    test_listener_edges();
    test_backpressure();
    for (int ph = 0; ph < 4; ph++) begin
      apply_setting($urandom_range(0, 2) == 0 ? 32'hFFFF_FFFF : $urandom,
                    3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom),
                    $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom), 16'($urandom));
      test_random_traffic(16);
    end
    // last stretch runs at full rate on both sides
    calm = 1'b1;
    test_random_traffic(12);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (verdict_q.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
